[sv/gcr_pkg.sv]
// Shared types, widths and register codes for the grid cell range block.
package gcr_pkg;

    // Configuration port.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WIDTH_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WIDTH_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WIDTH_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNTS = 3'd6;

    // Register widths and reset values.
    localparam int ORIGIN_W = 32;
    localparam int INV_W    = 32;
    localparam int COUNTS_W = 30;
    localparam logic [INV_W-1:0]    INV_WIDTH_RST   = 32'd65536;
    localparam logic [COUNTS_W-1:0] CELL_COUNTS_RST = 30'd1049601;

    // Per-axis cell count field and the axis count.
    localparam int CNT_W  = 10;
    localparam int N_AXES = 3;

    // Cell index, signed, saturated to IDX_MIN..IDX_MAX.
    localparam int IDX_W = 12;
    localparam logic signed [IDX_W-1:0] IDX_MAX = 12'sd1024;
    localparam logic signed [IDX_W-1:0] IDX_MIN = -12'sd1;
    localparam logic signed [IDX_W-1:0] IDX_ONE = 12'sd1;
    localparam logic signed [IDX_W-1:0] IDX_ZERO = 12'sd0;

    // Reduced quotient: each partial term is capped at SAT_CAP, so the sum
    // still decides both saturation thresholds exactly.
    localparam int SAT_W = 12;
    localparam int Q_W   = 13;
    localparam int KEEP_W = 11;
    localparam logic [SAT_W-1:0] SAT_CAP   = 12'd2048;
    localparam logic [Q_W-1:0]   Q_POS_SAT = 13'd1023;
    localparam logic [Q_W-1:0]   Q_NEG_SAT = 13'd2;

    // Default parameter values.
    localparam int MAX_CELLS_DEF  = 1023;
    localparam int COORD_BITS_DEF = 32;

    // Control word handed to each range tracker.
    typedef struct packed {
        logic step;
        logic last;
    } gcr_ctl_t;

endpackage

[sv/grid_cell_range_of_points_top.sv]
// Top level of the grid cell range block: configuration, pipeline and result word.
//
// The block takes the points of one element as a stream of input words
// (px, py, pz, last_point) on a valid/ready channel and, for the word marked
// last_point, delivers one result word (lo_x..hi_z, out_of_range) on a
// valid/ready output channel. Words without last_point give no result.
// Each axis forms a one-based cell index from the point, the grid origin and
// the reciprocal cell width, and the block keeps the running index box.
// A last word passes the offset register, loaded at the accepting edge,
// then the multiply register, then the result register, which drives
// out_valid. Throughput is one word per cycle while the pipeline is not
// stalled, as every stage takes a new word at each edge it advances.
// The output register holds one result. When it is full and the receiver
// holds out_ready low, the pipeline stalls, and in_ready falls, only once a
// further last word has reached the result stage; other words still flow.
// Reset clears the running box, the sticky out-of-range flag, all valid
// flags and the configuration registers to their defaults (origin zero,
// unit reciprocal width, one cell per axis). Configuration is written
// through cfg_we/cfg_index/cfg_data by the user only while no word is in
// flight (not enforced); an index beyond the cell count register is ignored.
module grid_cell_range_of_points_top
    import gcr_pkg::*;
#(
    parameter int MAX_CELLS  = MAX_CELLS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    input  logic signed [COORD_BITS-1:0] pz,
    input  logic                         last_point,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [IDX_W-1:0]      lo_x,
    output logic signed [IDX_W-1:0]      lo_y,
    output logic signed [IDX_W-1:0]      lo_z,
    output logic signed [IDX_W-1:0]      hi_x,
    output logic signed [IDX_W-1:0]      hi_y,
    output logic signed [IDX_W-1:0]      hi_z,
    output logic                         out_of_range
);

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CELLS);

    // Configuration registers.
    logic signed [ORIGIN_W-1:0] origin_reg [N_AXES];
    logic [INV_W-1:0]           inv_reg [N_AXES];
    logic [COUNTS_W-1:0]        counts_reg;

    // Pipeline control.
    logic stall;
    logic advance;
    logic accept;
    logic v1_reg;
    logic v2_reg;
    logic last1_reg;
    logic last2_reg;
    gcr_ctl_t ctl;

    // Per-axis signals.
    logic signed [COORD_BITS-1:0] coord [N_AXES];
    logic signed [IDX_W-1:0]      idx [N_AXES];
    logic [CNT_W-1:0]             cnt [N_AXES];
    logic signed [IDX_W-1:0]      lo [N_AXES];
    logic signed [IDX_W-1:0]      hi [N_AXES];
    logic [N_AXES-1:0]            outside;

    // Result state.
    logic any_outside_reg;
    logic any_outside_next;
    logic flag_merged;
    logic out_valid_reg;
    logic out_valid_next;
    logic signed [IDX_W-1:0] lo_reg [N_AXES];
    logic signed [IDX_W-1:0] hi_reg [N_AXES];
    logic flag_reg;

    // Configuration writes; unknown indexes fall through the default arm.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < N_AXES; a++)
            begin
                origin_reg[a] <= '0;
                inv_reg[a]    <= INV_WIDTH_RST;
            end
            counts_reg <= CELL_COUNTS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:    origin_reg[0] <= $signed(cfg_data[ORIGIN_W-1:0]);
                REG_ORIGIN_Y:    origin_reg[1] <= $signed(cfg_data[ORIGIN_W-1:0]);
                REG_ORIGIN_Z:    origin_reg[2] <= $signed(cfg_data[ORIGIN_W-1:0]);
                REG_INV_WIDTH_X: inv_reg[0]    <= cfg_data[INV_W-1:0];
                REG_INV_WIDTH_Y: inv_reg[1]    <= cfg_data[INV_W-1:0];
                REG_INV_WIDTH_Z: inv_reg[2]    <= cfg_data[INV_W-1:0];
                REG_CELL_COUNTS: counts_reg    <= cfg_data[COUNTS_W-1:0];
                default:         ;
            endcase
        end
    end

    // The pipeline only has to wait when a last word would overwrite a
    // result that the receiver has not yet taken.
    assign stall    = v2_reg && last2_reg && out_valid_reg && !out_ready;
    assign advance  = !stall;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            last1_reg <= last_point;
            last2_reg <= last1_reg;
        end
    end

    assign ctl.step = v2_reg && advance;
    assign ctl.last = last2_reg;

    assign coord[0] = px;
    assign coord[1] = py;
    assign coord[2] = pz;

    for (genvar a = 0; a < N_AXES; a++)
    begin : g_axis
        // Count field, limited to the largest grid the block supports.
        assign cnt[a] = (counts_reg[CNT_W*a +: CNT_W] > CNT_LIMIT)
                        ? CNT_LIMIT : counts_reg[CNT_W*a +: CNT_W];

        gcr_axis #(
            .COORD_BITS (COORD_BITS)
        ) u_axis (
            .clk       (clk),
            .en        (advance),
            .coord     (coord[a]),
            .origin    (origin_reg[a]),
            .inv_width (inv_reg[a]),
            .idx       (idx[a])
        );

        gcr_bound u_bound (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .idx     (idx[a]),
            .cnt     (cnt[a]),
            .lo      (lo[a]),
            .hi      (hi[a]),
            .outside (outside[a])
        );
    end

    // The out-of-range flag is sticky over all points of one element.
    assign flag_merged = any_outside_reg || (|outside);

    always_comb
    begin
        any_outside_next = any_outside_reg;
        if (ctl.step)
            any_outside_next = ctl.last ? 1'b0 : flag_merged;
    end

    always_comb
    begin
        if (ctl.step && ctl.last)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_outside_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            any_outside_reg <= any_outside_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (ctl.step && ctl.last)
        begin
            for (int a = 0; a < N_AXES; a++)
            begin
                lo_reg[a] <= lo[a];
                hi_reg[a] <= hi[a];
            end
            flag_reg <= flag_merged;
        end
    end

    assign out_valid    = out_valid_reg;
    assign lo_x         = lo_reg[0];
    assign lo_y         = lo_reg[1];
    assign lo_z         = lo_reg[2];
    assign hi_x         = hi_reg[0];
    assign hi_y         = hi_reg[1];
    assign hi_z         = hi_reg[2];
    assign out_of_range = flag_reg;

endmodule

[sv/gcr_axis.sv]
// Cell index pipeline for one axis: offset and magnitude, scale, saturate.
module gcr_axis
    import gcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [COORD_BITS-1:0] coord,
    input  logic signed [ORIGIN_W-1:0]  origin,
    input  logic [INV_W-1:0]            inv_width,
    output logic signed [IDX_W-1:0]     idx
);

    localparam int DW    = ((COORD_BITS > ORIGIN_W) ? COORD_BITS : ORIGIN_W) + 1;
    localparam int MAG_W = (DW > 64) ? 64 : DW;
    localparam int HI_W  = MAG_W - 32;
    localparam int HP_W  = HI_W + INV_W;

    logic signed [DW-1:0] coord_ext;
    logic signed [DW-1:0] origin_ext;
    logic signed [DW-1:0] diff_pos;
    logic signed [DW-1:0] diff_neg;
    logic [DW-1:0]        mag;

    logic [MAG_W-1:0] mag_reg;
    logic             neg1_reg;

    logic [HP_W-1:0]       hi_prod;
    logic [64-1:0]         lo_prod;
    logic [HP_W-1:0]       hi_prod_reg;
    logic [INV_W-1:0]      lo_part_reg;
    logic                  neg2_reg;

    logic [SAT_W-1:0] hi_sat;
    logic [SAT_W-1:0] lo_sat;
    logic [Q_W-1:0]   q;

    // Stage one: both differences in parallel; the sign picks the magnitude.
    assign coord_ext  = DW'(coord);
    assign origin_ext = DW'(origin);
    assign diff_pos   = coord_ext - origin_ext;
    assign diff_neg   = origin_ext - coord_ext;
    assign mag        = diff_pos[DW-1] ? diff_neg : diff_pos;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= mag[MAG_W-1:0];
            neg1_reg <= diff_pos[DW-1];
        end
    end

    // Stage two: the magnitude's upper and lower words are scaled separately.
    assign hi_prod = HP_W'(mag_reg[MAG_W-1:32]) * HP_W'(inv_width);
    assign lo_prod = 64'(mag_reg[31:0]) * 64'(inv_width);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_prod_reg <= hi_prod;
            lo_part_reg <= lo_prod[63:32];
            neg2_reg    <= neg1_reg;
        end
    end

    // Stage three: cap both terms, add, then map to a one-based index.
    assign hi_sat = (|hi_prod_reg[HP_W-1:KEEP_W]) ? SAT_CAP
                                                  : {1'b0, hi_prod_reg[KEEP_W-1:0]};
    assign lo_sat = (|lo_part_reg[INV_W-1:KEEP_W]) ? SAT_CAP
                                                   : {1'b0, lo_part_reg[KEEP_W-1:0]};
    assign q      = {1'b0, hi_sat} + {1'b0, lo_sat};

    always_comb
    begin
        if (neg2_reg)
        begin
            if (q >= Q_NEG_SAT)
                idx = IDX_MIN;
            else
                idx = q[0] ? IDX_ZERO : IDX_ONE;
        end
        else
        begin
            if (q >= Q_POS_SAT)
                idx = IDX_MAX;
            else
                idx = $signed(q[IDX_W-1:0]) + IDX_ONE;
        end
    end

endmodule

[sv/gcr_bound.sv]
// Running minimum and maximum cell index for one axis, with range check.
module gcr_bound
    import gcr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  gcr_ctl_t                ctl,
    input  logic signed [IDX_W-1:0] idx,
    input  logic [CNT_W-1:0]        cnt,
    output logic signed [IDX_W-1:0] lo,
    output logic signed [IDX_W-1:0] hi,
    output logic                    outside
);

    logic signed [IDX_W-1:0] run_lo_reg;
    logic signed [IDX_W-1:0] run_lo_next;
    logic signed [IDX_W-1:0] run_hi_reg;
    logic signed [IDX_W-1:0] run_hi_next;
    logic signed [IDX_W-1:0] hi_merged;
    logic signed [IDX_W-1:0] cnt_ext;
    logic signed [IDX_W-1:0] cnt_p1;

    assign cnt_ext   = $signed({{(IDX_W-CNT_W){1'b0}}, cnt});
    assign cnt_p1    = cnt_ext + IDX_ONE;
    assign lo        = (idx < run_lo_reg) ? idx : run_lo_reg;
    assign hi_merged = (idx > run_hi_reg) ? idx : run_hi_reg;
    assign hi        = (hi_merged == cnt_p1) ? cnt_ext : hi_merged;
    assign outside   = (idx < IDX_ONE) || (idx > cnt_p1);

    always_comb
    begin
        run_lo_next = run_lo_reg;
        run_hi_next = run_hi_reg;
        if (ctl.step)
        begin
            if (ctl.last)
            begin
                run_lo_next = IDX_MAX;
                run_hi_next = IDX_MIN;
            end
            else
            begin
                run_lo_next = lo;
                run_hi_next = hi_merged;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_lo_reg <= IDX_MAX;
            run_hi_reg <= IDX_MIN;
        end
        else
        begin
            run_lo_reg <= run_lo_next;
            run_hi_reg <= run_hi_next;
        end
    end

endmodule

[test/testbench.sv]
// Self-checking testbench for the grid cell range block.
`timescale 1ns / 1ps

// The testbench streams the points of many elements into the block and checks
// every index box that comes out. It has its own model of the block, written
// here, and works out each expected box as each input word is accepted.
//
// Structure:
//   - test tasks, called in turn from one initial block: the reset grid, a zero
//     reciprocal width with zero cell counts, saturation at both ends, a write
//     to the unused register index, and a long random run over many grids;
//   - send_point, which moves one input word across the valid/ready channel and
//     feeds the accepted point to the model;
//   - a checking process, which compares each accepted result word field by
//     field with the oldest box in pending_boxes.
// The sender works in bursts with random gaps, and in some phases without gaps.
// The receiver stalls on a pattern of its own that cycles through four modes.
module testbench
    import gcr_pkg::*;
();

    typedef logic [COORD_BITS_DEF-1:0] coord_t;
    typedef logic signed [IDX_W-1:0] idx_t;

    // One expected result word: the index box of an element and its flag.
    typedef struct packed {
        idx_t lo_x;
        idx_t lo_y;
        idx_t lo_z;
        idx_t hi_x;
        idx_t hi_y;
        idx_t hi_z;
        logic oor;
    } cell_box_t;

    // The block decodes indices 0 to 6; index 7 must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    coord_t               px           = '0;
    coord_t               py           = '0;
    coord_t               pz           = '0;
    logic                 last_point   = 1'b0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    idx_t                 lo_x;
    idx_t                 lo_y;
    idx_t                 lo_z;
    idx_t                 hi_x;
    idx_t                 hi_y;
    idx_t                 hi_z;
    logic                 out_of_range;

    // Model copy of the configuration registers, at their reset values.
    logic [ORIGIN_W-1:0] grid_origin [N_AXES] = '{default: '0};
    logic [INV_W-1:0]    grid_inv    [N_AXES] = '{default: INV_WIDTH_RST};
    logic [COUNTS_W-1:0] grid_counts          = CELL_COUNTS_RST;

    // Model copy of the running box of the element being received.
    int box_lo [N_AXES] = '{default: int'(IDX_MAX)};
    int box_hi [N_AXES] = '{default: int'(IDX_MIN)};
    bit box_outside     = 1'b0;

    cell_box_t pending_boxes [$];

    int  mismatches    = 0;
    int  points_sent   = 0;
    int  boxes_due     = 0;
    int  boxes_checked = 0;
    int  grids_used    = 1;
    int  burst_left    = 0;
    bit  gaps_on       = 1'b1;
    int  rx_tick       = 0;

    grid_cell_range_of_points_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .px           (px),
        .py           (py),
        .pz           (pz),
        .last_point   (last_point),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .lo_x         (lo_x),
        .lo_y         (lo_y),
        .lo_z         (lo_z),
        .hi_x         (hi_x),
        .hi_y         (hi_y),
        .hi_z         (hi_z),
        .out_of_range (out_of_range)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------

    // Cells along one axis, taken from the packed count register.
    function automatic int axis_cells(int a);
        int cnt;
        cnt = int'(grid_counts[CNT_W*a +: CNT_W]);
        if (cnt > MAX_CELLS_DEF)
            cnt = MAX_CELLS_DEF;
        return cnt;
    endfunction

    // One-based cell index of a coordinate. The distance from the origin is
    // exact in 33 bits; its magnitude times the reciprocal width is truncated
    // to an integer, so the index rounds toward zero, and the sign goes back
    // on afterwards. The result saturates to -1..1024.
    function automatic int cell_of_coord(coord_t coord, logic [ORIGIN_W-1:0] org,
                                         logic [INV_W-1:0] inv);
        logic signed [63:0] c;
        logic signed [63:0] o;
        logic [63:0]        mag;
        logic [63:0]        q;
        logic               neg;
        c   = {{(64-COORD_BITS_DEF){coord[COORD_BITS_DEF-1]}}, coord};
        o   = {{(64-ORIGIN_W){org[ORIGIN_W-1]}}, org};
        neg = c < o;
        mag = neg ? o - c : c - o;
        q   = 64'(mag[63:32]) * 64'(inv);
        q   = q + ((64'(mag[31:0]) * 64'(inv)) >> 32);
        if (neg)
            return (q >= 64'd2) ? int'(IDX_MIN) : 1 - int'(q);
        return (q >= 64'(int'(IDX_MAX) - 1)) ? int'(IDX_MAX) : int'(q) + 1;
    endfunction

    // Largest index of an axis, with a maximum of count+1 pulled back to count.
    function automatic idx_t clamped_top(int a);
        int cnt;
        cnt = axis_cells(a);
        return idx_t'((box_hi[a] == cnt + 1) ? cnt : box_hi[a]);
    endfunction

    // Fold one accepted point into the running box; on the last point of an
    // element, queue the finished box and start afresh.
    function automatic void track_point(coord_t x, coord_t y, coord_t z, logic last);
        coord_t    pt [N_AXES];
        int        idx;
        int        cnt;
        cell_box_t box;
        pt[0] = x;
        pt[1] = y;
        pt[2] = z;
        for (int a = 0; a < N_AXES; a++)
        begin
            cnt = axis_cells(a);
            idx = cell_of_coord(pt[a], grid_origin[a], grid_inv[a]);
            if (idx < box_lo[a])
                box_lo[a] = idx;
            if (idx > box_hi[a])
                box_hi[a] = idx;
            if (idx < 1 || idx > cnt + 1)
                box_outside = 1'b1;
        end
        if (!last)
            return;
        box.lo_x = idx_t'(box_lo[0]);
        box.lo_y = idx_t'(box_lo[1]);
        box.lo_z = idx_t'(box_lo[2]);
        box.hi_x = clamped_top(0);
        box.hi_y = clamped_top(1);
        box.hi_z = clamped_top(2);
        box.oor  = box_outside;
        pending_boxes = {pending_boxes, box};
        boxes_due++;
        for (int a = 0; a < N_AXES; a++)
        begin
            box_lo[a] = int'(IDX_MAX);
            box_hi[a] = int'(IDX_MIN);
        end
        box_outside = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Sender, configuration and receiver
    // ------------------------------------------------------------------

    // Send one point word. When a burst runs out the sender drops valid for a
    // random gap first. The task returns at the edge that accepted the word and
    // leaves valid high, so that back-to-back words keep valid asserted.
    task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                              input logic last);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        in_valid   <= 1'b1;
        px         <= x;
        py         <= y;
        pz         <= z;
        last_point <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_point(x, y, z, last);
        points_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // Wait for the block to go quiet: no word offered, every expected box
    // delivered, and no point left inside the pipeline.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_boxes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Load a complete grid: all seven registers, and optionally a write of
    // zero to the unused index, which must change nothing. The two spare bits
    // above the cell count fields carry random junk.
    task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] oz, input logic [31:0] ix,
                            input logic [31:0] iy, input logic [31:0] iz,
                            input logic [COUNTS_W-1:0] counts, input bit poke_unused);
        logic [CFG_W-1:0] value [8];
        logic [1:0]       junk;
        int               n_writes;
        junk                    = 2'($urandom);
        value[REG_ORIGIN_X]     = ox;
        value[REG_ORIGIN_Y]     = oy;
        value[REG_ORIGIN_Z]     = oz;
        value[REG_INV_WIDTH_X]  = ix;
        value[REG_INV_WIDTH_Y]  = iy;
        value[REG_INV_WIDTH_Z]  = iz;
        value[REG_CELL_COUNTS]  = {junk, counts};
        value[REG_UNUSED]       = '0;
        n_writes = poke_unused ? int'(REG_UNUSED) + 1 : int'(REG_UNUSED);
        settle();
        for (int r = 0; r < n_writes; r++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= value[r];
            @(posedge clk);
            case (CFG_IDX_W'(r))
                REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z:
                    grid_origin[r] = value[r];
                REG_INV_WIDTH_X, REG_INV_WIDTH_Y, REG_INV_WIDTH_Z:
                    grid_inv[r - int'(REG_INV_WIDTH_X)] = value[r];
                REG_CELL_COUNTS:
                    grid_counts = value[r][COUNTS_W-1:0];
                default:
                    ;
            endcase
        end
        cfg_we <= 1'b0;
        grids_used++;
    endtask

    // Receiver pattern, one mode per value of rx_tick[9:8]: always ready, lightly
    // stalled, a fixed stall window in each period of rx_tick[4:0], and mostly stalled.
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        case (rx_tick[9:8])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: out_ready <= (rx_tick[4:0] >= 5'd20);
            default: out_ready <= ($urandom_range(0, 9) < 2);
        endcase
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void compare_index(string field, idx_t want, idx_t got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        cell_box_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_boxes.size() == 0)
            begin
                $display({"%0t: result word expected none, ",
                          "got lo %0d %0d %0d hi %0d %0d %0d oor %0b"},
                         $time, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, out_of_range);
                mismatches++;
            end
            else
            begin
                want = pending_boxes.pop_front();
                compare_index("lo_x", want.lo_x, lo_x);
                compare_index("lo_y", want.lo_y, lo_y);
                compare_index("lo_z", want.lo_z, lo_z);
                compare_index("hi_x", want.hi_x, hi_x);
                compare_index("hi_y", want.hi_y, hi_y);
                compare_index("hi_z", want.hi_z, hi_z);
                compare_index("out_of_range", idx_t'(want.oor), idx_t'(out_of_range));
                boxes_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The reset grid: origin zero, unit cells, one cell per axis. Covers an
    // exact cell boundary, a tiny negative offset that truncates toward zero
    // to index 1, indices 0 and -1, and both coordinate extremes saturating.
    task automatic test_default_grid();
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_point(32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b0);
        send_point(32'h0002_0000, 32'hFFFF_0000, 32'hFFFE_0000, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b1);
    endtask

    // A zero reciprocal width puts every point in cell 1, whatever the origin.
    // With the count fields at zero only index 1 is in range, and a maximum of
    // 1 is pulled back to 0. Then a non-zero width with zero counts on two axes
    // flags a point in cell 2.
    task automatic test_zero_width();
        set_grid(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0, 32'h0, 32'h0, 30'h0, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        set_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                 {10'd0, 10'd5, 10'd0}, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
    endtask

    // Origins and reciprocal widths at their extremes with 1023 cells per axis.
    // A saturated 1024 along x equals count+1, so it is clamped to 1023 and not
    // flagged; along y the distance saturates at -1; along z the smallest
    // non-zero width keeps every point in cell 1.
    task automatic test_saturation();
        set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 30'h3FFF_FFFF, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
    endtask

    // Uneven cells and counts per axis, loaded together with a zero written to
    // the unused register index. Had that write landed on the counts, every
    // point beyond cell 1 would be flagged.
    task automatic test_unused_index();
        set_grid(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000,
                 32'h0000_8000, 32'h0002_0000, 32'h0001_0000,
                 {10'd5, 10'd4, 10'd3}, 1'b1);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0004_0000, 1'b0);
        send_point(32'h0005_0000, 32'h0000_8000, 32'h0006_0000, 1'b0);
        send_point(32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 1'b1);
    endtask

    // A coordinate for one axis of the current grid. Half land in or just
    // around the grid, a share exactly on a cell boundary or one unit below
    // it, and the rest are the extremes, the origin itself or any value.
    function automatic coord_t pick_coord(int a);
        logic [63:0] span;
        logic [63:0] off;
        int          cnt;
        int          k;
        cnt = axis_cells(a);
        case ($urandom_range(0, 19))
            0, 1, 2: return coord_t'($urandom);
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            5: return grid_origin[a];
            6, 7, 8, 9:
            begin
                if (grid_inv[a] == '0)
                    return coord_t'($urandom);
                k   = $urandom_range(0, cnt + 2);
                off = ((64'(k) << 32) + 64'(grid_inv[a]) - 64'd1) / 64'(grid_inv[a]);
                return grid_origin[a] + off[31:0] - 32'($urandom_range(0, 1));
            end
            default:
            begin
                if (grid_inv[a] == '0)
                    span = 64'h7FFF_FFFF;
                else
                    span = (64'(cnt + 3) << 32) / 64'(grid_inv[a]);
                if (span > 64'h7FFF_FFFF)
                    span = 64'h7FFF_FFFF;
                if (span < 64'd8)
                    span = 64'd8;
                off = {$urandom, $urandom} % (span + span / 4);
                off = off - span / 8;
                return grid_origin[a] + off[31:0];
            end
        endcase
    endfunction

    // Random grids, each followed by a run of whole elements. Most grids are
    // moderate; now and then an origin, a width or a count takes an extreme.
    // One phase in three runs the sender without gaps.
    task automatic test_random_elements(input int target);
        logic [31:0]         org [N_AXES];
        logic [31:0]         inv [N_AXES];
        logic [CNT_W-1:0]    cnt [N_AXES];
        int                  phase;
        int                  phase_points;
        int                  n_pts;
        phase = 0;
        while (points_sent < target)
        begin
            for (int a = 0; a < N_AXES; a++)
            begin
                case ($urandom_range(0, 9))
                    0: org[a] = 32'h8000_0000;
                    1: org[a] = 32'h7FFF_FFFF;
                    2: org[a] = $urandom;
                    default: org[a] = 32'($signed($urandom) >>> 6);
                endcase
                case ($urandom_range(0, 9))
                    0: inv[a] = 32'h0;
                    1: inv[a] = 32'hFFFF_FFFF;
                    2: inv[a] = $urandom;
                    default: inv[a] = $urandom_range(1, 32'h0040_0000);
                endcase
                case ($urandom_range(0, 9))
                    0: cnt[a] = '0;
                    1: cnt[a] = 10'd1023;
                    2: cnt[a] = CNT_W'($urandom);
                    default: cnt[a] = CNT_W'($urandom_range(1, 40));
                endcase
            end
            set_grid(org[0], org[1], org[2], inv[0], inv[1], inv[2],
                     {cnt[2], cnt[1], cnt[0]}, ($urandom_range(0, 3) == 0));
            gaps_on      = (phase % 3 != 2);
            burst_left   = 0;
            phase_points = 0;
            while (phase_points < 110 && points_sent < target)
            begin
                n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 6);
                for (int p = 0; p < n_pts; p++)
                    send_point(pick_coord(0), pick_coord(1), pick_coord(2),
                               p == n_pts - 1);
                phase_points += n_pts;
            end
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_grid();
        test_zero_width();
        test_saturation();
        test_unused_index();
        test_random_elements(1350);
        // Let the last boxes drain, then allow the pipeline depth and a margin.
        in_valid <= 1'b0;
        while (pending_boxes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Run covered %0d points in %0d elements over %0d grid settings;",
                 points_sent, boxes_due, grids_used);
        $display("%0d result words checked, %0d mismatches.", boxes_checked, mismatches);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Run stopped by the timeout with %0d boxes outstanding.",
                 pending_boxes.size());
        $display("testbench: FAIL");
        $finish;
    end

endmodule
